// ===== rtl/utu_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package utu_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        bad_input;
    logic        run_last;
    logic        string_done;
  } out_item_t;

  // Results produced by one decoded byte, handed to the output queue.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  // Byte class limits.
  localparam logic [7:0]  ASCII_MAX    = 8'h7F;
  localparam logic [7:0]  CONT_MAX     = 8'hBF;
  localparam logic [7:0]  LEAD2_MAX    = 8'hDF;
  localparam logic [7:0]  LEAD3_MAX    = 8'hEF;
  localparam logic [7:0]  LEAD4_MAX    = 8'hF7;
  localparam logic [7:0]  CONT_MIN     = 8'h80;

  // Code point limits.
  localparam logic [20:0] SURR_MIN     = 21'h00D800;
  localparam logic [20:0] SURR_MAX     = 21'h00DFFF;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;
  localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;  // 0xDC00 >> 10

  // Partial code point holds at most 15 bits before the final continuation.
  localparam int PARTIAL_W = 15;

  localparam int UTU_QUEUE_DEPTH = 4;

endpackage

// ===== rtl/utu_decode.sv =====
// Byte decoder: sequence state and result generation for one byte per cycle while fire is high.
module utu_decode import utu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  in_item_t item,
  output push_t    push
);

  logic [PARTIAL_W-1:0] partial_r, partial_nxt;
  logic [1:0]           owed_r, owed_nxt;
  logic                 disc_r, disc_nxt;

  logic [7:0]  b;
  logic        d;
  logic        is_cont;
  logic [20:0] cp;
  logic [19:0] supp;
  logic        cp_bad;
  push_t       emit_push;
  push_t       fail_push;
  push_t       none_push;
  logic [1:0]  owed_dec;

  always_comb begin
    b        = item.text_byte;
    d        = item.string_last;
    is_cont  = (b >= CONT_MIN) && (b <= CONT_MAX);
    owed_dec = owed_r - 2'd1;
    cp       = (owed_r == 2'd0) ? {13'd0, b} : {partial_r, b[5:0]};
    cp_bad   = ((cp >= SURR_MIN) && (cp <= SURR_MAX)) || (cp > CP_MAX);
    supp     = 20'(cp - SUPP_BASE);

    none_push = '0;

    fail_push                    = '0;
    fail_push.count              = 2'd1;
    fail_push.first.bad_input    = 1'b1;
    fail_push.first.run_last     = 1'b1;
    fail_push.first.string_done  = d;

    emit_push = '0;
    if (cp_bad) begin
      emit_push = fail_push;
    end else if (cp <= BMP_MAX) begin
      emit_push.count             = 2'd1;
      emit_push.first.code_unit   = cp[15:0];
      emit_push.first.run_last    = 1'b1;
      emit_push.first.string_done = d;
    end else begin
      emit_push.count              = 2'd2;
      emit_push.first.code_unit    = {HI_SURR_TAG, supp[19:10]};
      emit_push.first.string_done  = d;
      emit_push.second.code_unit   = {LO_SURR_TAG, supp[9:0]};
      emit_push.second.run_last    = 1'b1;
      emit_push.second.string_done = d;
    end

    push        = none_push;
    partial_nxt = partial_r;
    owed_nxt    = owed_r;
    disc_nxt    = disc_r;

    if (disc_r) begin
      // dropping the rest of a bad string until its final byte
      if (d) begin
        partial_nxt = '0;
        owed_nxt    = 2'd0;
        disc_nxt    = 1'b0;
      end
    end else if (owed_r == 2'd0) begin
      if (b <= ASCII_MAX) begin
        push = emit_push;
      end else if (b <= CONT_MAX || b > LEAD4_MAX) begin
        push = fail_push;
      end else begin
        if (b <= LEAD2_MAX) begin
          partial_nxt = PARTIAL_W'(b[4:0]);
          owed_nxt    = 2'd1;
        end else if (b <= LEAD3_MAX) begin
          partial_nxt = PARTIAL_W'(b[3:0]);
          owed_nxt    = 2'd2;
        end else begin
          partial_nxt = PARTIAL_W'(b[2:0]);
          owed_nxt    = 2'd3;
        end
        if (d) begin
          push = fail_push;  // string ends right after a lead byte
        end
      end
    end else if (!is_cont) begin
      push = fail_push;
    end else if (owed_dec != 2'd0) begin
      partial_nxt = cp[PARTIAL_W-1:0];
      owed_nxt    = owed_dec;
      if (d) begin
        push = fail_push;
      end
    end else begin
      push        = emit_push;
      partial_nxt = '0;
      owed_nxt    = 2'd0;
    end

    // any error clears the sequence and starts dropping unless the string ends
    if (push.first.bad_input) begin
      partial_nxt = '0;
      owed_nxt    = 2'd0;
      disc_nxt    = !d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      owed_r    <= 2'd0;
      disc_r    <= 1'b0;
    end else if (fire) begin
      partial_r <= partial_nxt;
      owed_r    <= owed_nxt;
      disc_r    <= disc_nxt;
    end
  end

endmodule

// ===== rtl/utu_out_queue.sv =====
// Result queue: takes up to two results per cycle, delivers one per cycle unless out_stall is high.
module utu_out_queue import utu_pkg::*; #(
  parameter int Depth = UTU_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_en,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  out_item_t           mem_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt, wr_ptr1, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic [1:0]          n_push;
  logic                pop;

  always_comb begin
    n_push     = push_en ? push.count : 2'd0;
    pop        = out_valid && !out_stall;
    wr_ptr1    = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    wr_ptr_nxt = wr_ptr_r;
    case (n_push)
      2'd1:    wr_ptr_nxt = wr_ptr1;
      2'd2:    wr_ptr_nxt = (wr_ptr1 == LastPtr) ? '0 : wr_ptr1 + 1'b1;
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = rd_ptr_r;
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CntW'(n_push) - CntW'(pop);
  end

  assign room      = (count_r <= CntW'(Depth - 2));
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/utf8_to_utf16_transcoder_unit.sv =====
// A byte accepted is held in the input register, then decoded, and its first
//   code unit is written into the result queue and shown on out_valid.
// Throughput: one byte per cycle while the queue has room; one code unit leaves
//   per cycle unless out_stall holds it, so a surrogate pair leaves as two units.
// The result queue accepts a byte's results only with room for two entries.
// Reset (rst_n low, synchronous): empties the input register and the queue,
//   clears the partial code point, owed count and discard flag.
module utf8_to_utf16_transcoder_unit import utu_pkg::*; #(
  parameter int QueueDepth = UTU_QUEUE_DEPTH  // at least 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Input register: holds one byte until the queue can take its results.
  logic     in_vld_r;
  in_item_t in_item_r;
  logic     q_room;
  logic     fire;
  push_t    push;

  // A held byte decodes once the queue has two free entries.
  assign fire     = in_vld_r && q_room;
  assign in_stall = in_vld_r && !q_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  // Payload register, loaded only on an accepted item.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  // Sequence decode and state update.
  utu_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .push  (push)
  );

  // Result queue parts the decoder from the output handshake.
  utu_out_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (fire),
    .push      (push),
    .room      (q_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/utu_checker.sv =====
// Port-level checks for the transcoder, bound to the top level.
module utu_checker import utu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input item changed while stalled");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // error item carries a zero unit and ends its byte's results
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_input |->
      out_data.code_unit == 16'd0 && out_data.run_last)
    else $error("malformed error result");

  // high surrogate is never last, low surrogate always is
  a_surr_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.bad_input && out_data.code_unit[15:11] == HI_SURR_TAG[5:1]
      |-> out_data.run_last == out_data.code_unit[10])
    else $error("surrogate half marked wrong");

  // reset empties both sides
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("valid or stall right after reset");

endmodule

bind utf8_to_utf16_transcoder_unit utu_checker u_checker (.*);
